[rtl/mswt_pkg.sv]
`timescale 1ns / 1ps

package mswt_pkg;

	localparam int NUM_SLOTS  = 8;
	localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int MASK_W     = 8;
	localparam int HIT_W      = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;

	typedef enum logic [2:0] {
		MODE_ADVANCE = 3'd0,
		MODE_CLAIM   = 3'd1,
		MODE_ARM     = 3'd2,
		MODE_READ    = 3'd3,
		MODE_SET     = 3'd4
	} mode_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_PASSED = 2'd1;
	localparam logic [1:0] ST_NOFREE = 2'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  slot;
		logic [63:0] target_tick;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [2:0]        slot_index;
		logic [63:0]       tick_value;
		logic [MASK_W-1:0] fired_mask;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic fire;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_advance;
	} dp_status_t;

endpackage

[rtl/mswt_ctrl.sv]
`timescale 1ns / 1ps

module mswt_ctrl import mswt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	output ctl_cmd_t   cmd,
	input  dp_status_t stat
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FIRE
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (stat.is_advance) begin
						state_q <= S_FIRE;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_FIRE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign cmd.latch = start && (state_q == S_IDLE);
	assign cmd.exec  = (state_q == S_EXEC);
	assign cmd.fire  = (state_q == S_FIRE);

endmodule

[rtl/mswt_datapath.sv]
`timescale 1ns / 1ps

module mswt_datapath import mswt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_cmd_t   cmd,
	input  in_item_t   request,
	output dp_status_t stat,
	output out_item_t  result
);

	in_item_t        req_q;
	logic [63:0]     tick_q;
	logic            claimed_q [NUM_SLOTS];
	logic [63:0]     wake_q    [NUM_SLOTS];
	out_item_t       res_q;

	logic                  free_found;
	logic [SLOT_IDX_W-1:0] free_idx;
	logic [HIT_W-1:0]      hit;

	// lowest unclaimed slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!claimed_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_IDX_W'(i);
			end
		end
	end

	// slots due at the already incremented count
	always_comb begin
		hit = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			hit[i] = claimed_q[i] && (wake_q[i] != 64'd0) && (wake_q[i] <= tick_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= request;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 64'd0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				claimed_q[i] <= 1'b0;
				wake_q[i]    <= 64'd0;
			end
		end else if (cmd.exec) begin
			case (req_q.mode)
				MODE_ADVANCE: tick_q <= tick_q + 64'd1;
				MODE_CLAIM: begin
					if (free_found) claimed_q[free_idx] <= 1'b1;
				end
				MODE_ARM: begin
					if (req_q.target_tick > tick_q) begin
						for (int i = 0; i < NUM_SLOTS; i++) begin
							if (32'(req_q.slot) == i) wake_q[i] <= req_q.target_tick;
						end
					end
				end
				MODE_SET: tick_q <= req_q.target_tick;
				default: ;
			endcase
		end else if (cmd.fire) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (hit[i]) wake_q[i] <= 64'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q.status     <= ST_OK;
			res_q.slot_index <= 3'd0;
			res_q.tick_value <= tick_q;
			res_q.fired_mask <= '0;
			case (req_q.mode)
				MODE_CLAIM: begin
					if (free_found) res_q.slot_index <= 3'(free_idx);
					else            res_q.status     <= ST_NOFREE;
				end
				MODE_ARM: begin
					if (req_q.target_tick <= tick_q) res_q.status <= ST_PASSED;
				end
				MODE_SET: res_q.tick_value <= req_q.target_tick;
				default: ;
			endcase
		end else if (cmd.fire) begin
			res_q.tick_value <= tick_q;
			res_q.fired_mask <= hit[MASK_W-1:0];
		end
	end

	assign stat.is_advance = (req_q.mode == MODE_ADVANCE);
	assign result          = res_q;

endmodule

[rtl/multi_slot_wakeup_timer.sv]
`timescale 1ns / 1ps
// Channel   Signals                 Transfer
// --------  ----------------------  -----------------------------------------
// request   start, busy, request    edge with start high and busy low
// result    done, result            edge ending the single cycle done is high
//
// Sequencing: an advance transfer passes latch, increment and slot compare
// before its result is shown; every other mode passes latch and execute. The
// next start is taken in the cycle the result is shown, so a new item is
// accepted only once the last one is through; the controller sets this.
// Reset: arst_n clears the count, the claimed flags and all wake ticks.
// Stalls: the receiver cannot stall; done lasts exactly one cycle.

module multi_slot_wakeup_timer import mswt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  request,
	output logic      done,
	output out_item_t result
);

	ctl_cmd_t   cmd;
	dp_status_t stat;

	// sequencing: idle -> exec (-> fire for advance) -> idle with done
	mswt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// count, slot flags and wake ticks; result register
	mswt_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.stat    (stat),
		.result  (result)
	);

endmodule

[rtl/mswt_checker.sv]
`timescale 1ns / 1ps

module mswt_checker import mswt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_item_t result
);

	// a transfer always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");

	// results never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done high for two cycles");

	// a result follows a busy period and is shown while idle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result without preceding work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status != 2'd3))
		else $error("illegal status code");

	// refused results carry no fired slots
	a_mask_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |-> (result.fired_mask == '0))
		else $error("fired mask on refused request");

endmodule

bind multi_slot_wakeup_timer mswt_checker u_mswt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);
